// ===== src/nfa_pkg.sv =====
`timescale 1ns / 1ps

package nfa_pkg;

    localparam int ADDR_W = 36;

    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO     = 2'd1;
    localparam logic [1:0] STAT_NO_MEM   = 2'd2;
    localparam logic [1:0] STAT_NO_INIT  = 2'd3;

    localparam logic [16:0] CHUNK_RESET = 17'd4096;

    // datapath operations
    localparam logic [5:0] OP_NOP      = 6'd0;
    localparam logic [5:0] OP_SETSTAT  = 6'd1;
    localparam logic [5:0] OP_SET_INIT = 6'd2;
    localparam logic [5:0] OP_EMIT     = 6'd3;
    localparam logic [5:0] OP_INIT0    = 6'd4;
    localparam logic [5:0] OP_INIT1    = 6'd5;
    localparam logic [5:0] OP_INIT2    = 6'd6;
    localparam logic [5:0] OP_INIT3    = 6'd7;
    localparam logic [5:0] OP_G0       = 6'd8;
    localparam logic [5:0] OP_G1       = 6'd9;
    localparam logic [5:0] OP_G2       = 6'd10;
    localparam logic [5:0] OP_G3       = 6'd11;
    localparam logic [5:0] OP_M0       = 6'd12;
    localparam logic [5:0] OP_M1       = 6'd13;
    localparam logic [5:0] OP_M2       = 6'd14;
    localparam logic [5:0] OP_M3       = 6'd15;
    localparam logic [5:0] OP_M4       = 6'd16;
    localparam logic [5:0] OP_M5       = 6'd17;
    localparam logic [5:0] OP_MA1      = 6'd18;
    localparam logic [5:0] OP_MA2      = 6'd19;
    localparam logic [5:0] OP_MB1      = 6'd20;
    localparam logic [5:0] OP_MB2      = 6'd21;
    localparam logic [5:0] OP_MC_RD    = 6'd22;
    localparam logic [5:0] OP_MC_1     = 6'd23;
    localparam logic [5:0] OP_MC_RD2   = 6'd24;
    localparam logic [5:0] OP_MC_2     = 6'd25;
    localparam logic [5:0] OP_M_END    = 6'd26;
    localparam logic [5:0] OP_F_START  = 6'd27;
    localparam logic [5:0] OP_F0       = 6'd28;
    localparam logic [5:0] OP_F1       = 6'd29;
    localparam logic [5:0] OP_F2       = 6'd30;
    localparam logic [5:0] OP_GROW_REQ = 6'd31;
    localparam logic [5:0] OP_C0       = 6'd32;
    localparam logic [5:0] OP_C1       = 6'd33;
    localparam logic [5:0] OP_C2S      = 6'd34;
    localparam logic [5:0] OP_C3       = 6'd35;
    localparam logic [5:0] OP_C4       = 6'd36;
    localparam logic [5:0] OP_C2N      = 6'd37;
    localparam logic [5:0] OP_R0       = 6'd38;
    localparam logic [5:0] OP_R1       = 6'd39;
    localparam logic [5:0] OP_R2       = 6'd40;

    typedef struct packed {
        logic [5:0] op;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       init;
        logic       req_zero;
        logic       free_ok;
        logic       fits;
        logic       a_zero;
        logic       found;
        logic       stop;
        logic       split;
        logic       pa;
        logic       na;
    } sts_t;

endpackage

// ===== src/nfa_dpath.sv =====
`timescale 1ns / 1ps

module nfa_dpath #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nfa_pkg::cmd_t       cmd,
    output nfa_pkg::sts_t       sts,
    input  logic                in_accept,
    input  logic [1:0]          in_kind,
    input  logic [16:0]         in_request_size,
    input  logic [15:0]         in_block_addr,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_data,
    output logic [15:0]         out_result_addr,
    output logic [1:0]          out_status
);

    localparam int AW         = nfa_pkg::ADDR_W;
    localparam int WORDS      = HEAP_BYTES / 4;
    localparam int IW         = $clog2(WORDS);
    localparam int SCAN_LIMIT = HEAP_BYTES / 8 + 4;
    localparam int CW         = $clog2(SCAN_LIMIT + 1);

    logic [31:0] mem [WORDS];

    logic [AW-1:0] a_reg, a_next, s_reg, s_next, p_reg, p_next, n_reg, n_next;
    logic [AW-1:0] psz_reg, psz_next, nsz_reg, nsz_next, start_reg, start_next;
    logic [AW-1:0] have_reg, have_next, brk_reg, brk_next, rover_reg, rover_next;
    logic [17:0]   g_reg, g_next, need_reg, need_next;
    logic [15:0]   res_reg, res_next, oaddr_reg, oaddr_next;
    logic [1:0]    stat_reg, stat_next, ostat_reg, ostat_next, kind_reg, kind_next;
    logic          pa_reg, pa_next, init_reg, init_next;
    logic          rzero_reg, rzero_next, fok_reg, fok_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [16:0]   chunk_reg;
    logic [31:0]   q_reg;
    logic          oob_reg;

    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wdata;
    logic          mem_inr;

    logic [31:0]   word;
    logic [AW-1:0] rsz;
    logic          ral;
    logic [18:0]   gsize;
    logic [AW-1:0] gsz_a, need_a, a_adv, a_wrap;
    logic [17:0]   need_calc;

    assign word   = oob_reg ? 32'd1 : q_reg;
    assign rsz    = {{(AW-32){1'b0}}, word[31:3], 3'b000};
    assign ral    = word[0];
    assign need_a = {{(AW-18){1'b0}}, need_reg};
    assign a_adv  = a_reg + rsz;
    assign a_wrap = (rsz == '0) ? AW'(8) : a_reg;

    // round to an even word count, at least 16 bytes
    always_comb begin
        gsize = {1'b0, g_reg[17:2], 2'b00} + (g_reg[2] ? 19'd4 : 19'd0);
        if (gsize < 19'd16) begin
            gsize = 19'd16;
        end
    end
    assign gsz_a = {{(AW-19){1'b0}}, gsize};

    assign need_calc = ({1'b0, in_request_size} <= 18'd8) ? 18'd16
                     : (({1'b0, in_request_size} + 18'd15) & ~18'd7);

    assign mem_inr = (mem_addr[AW-1:2] < (AW-2)'(WORDS));

    always_comb begin
        sts.kind     = kind_reg;
        sts.init     = init_reg;
        sts.req_zero = rzero_reg;
        sts.free_ok  = fok_reg;
        sts.fits     = (brk_reg + gsz_a) <= AW'(HEAP_BYTES);
        sts.a_zero   = (a_reg == '0);
        sts.found    = !ral && (need_a <= rsz);
        sts.stop     = (a_wrap == start_reg) || (cnt_reg == CW'(SCAN_LIMIT - 1));
        sts.split    = rsz >= (need_a + AW'(16));
        sts.pa       = pa_reg;
        sts.na       = ral;
    end

    always_comb begin
        a_next = a_reg; s_next = s_reg; p_next = p_reg; n_next = n_reg;
        psz_next = psz_reg; nsz_next = nsz_reg; start_next = start_reg;
        have_next = have_reg; brk_next = brk_reg; rover_next = rover_reg;
        g_next = g_reg; need_next = need_reg; res_next = res_reg;
        oaddr_next = oaddr_reg; stat_next = stat_reg; ostat_next = ostat_reg;
        kind_next = kind_reg; pa_next = pa_reg; init_next = init_reg;
        rzero_next = rzero_reg; fok_next = fok_reg; cnt_next = cnt_reg;
        mem_addr = a_reg - AW'(4);
        mem_we = 1'b0;
        mem_wdata = s_reg[31:0];
        if (in_accept) begin
            kind_next  = in_kind;
            rzero_next = (in_request_size == '0);
            need_next  = need_calc;
            a_next     = {{(AW-16){1'b0}}, in_block_addr};
            res_next   = '0;
            stat_next  = nfa_pkg::STAT_OK;
            fok_next   = (in_block_addr >= 16'd16) && (in_block_addr[2:0] == 3'b000)
                         && ({{(AW-16){1'b0}}, in_block_addr} < brk_reg);
        end
        unique case (cmd.op)
            nfa_pkg::OP_NOP: begin
            end
            nfa_pkg::OP_SETSTAT: stat_next = cmd.code;
            nfa_pkg::OP_SET_INIT: init_next = 1'b1;
            nfa_pkg::OP_EMIT: begin
                oaddr_next = res_reg;
                ostat_next = stat_reg;
            end
            nfa_pkg::OP_INIT0: begin
                brk_next = '0;
                init_next = 1'b0;
                mem_addr = '0; mem_we = 1'b1; mem_wdata = 32'd0;
            end
            nfa_pkg::OP_INIT1: begin
                mem_addr = AW'(4); mem_we = 1'b1; mem_wdata = 32'd9;
            end
            nfa_pkg::OP_INIT2: begin
                mem_addr = AW'(8); mem_we = 1'b1; mem_wdata = 32'd9;
            end
            nfa_pkg::OP_INIT3: begin
                mem_addr = AW'(12); mem_we = 1'b1; mem_wdata = 32'd1;
                brk_next = AW'(16);
                rover_next = AW'(8);
                g_next = {1'b0, chunk_reg};
            end
            nfa_pkg::OP_G0: begin
                s_next = gsz_a;
                a_next = brk_reg;
            end
            nfa_pkg::OP_G1: begin
                mem_we = 1'b1;
            end
            nfa_pkg::OP_G2: begin
                mem_addr = a_reg + s_reg - AW'(8); mem_we = 1'b1;
            end
            nfa_pkg::OP_G3: begin
                mem_addr = a_reg + s_reg - AW'(4); mem_we = 1'b1; mem_wdata = 32'd1;
                brk_next = a_reg + s_reg;
                rover_next = a_reg;
            end
            nfa_pkg::OP_M0: begin
            end
            nfa_pkg::OP_M1: begin
                s_next = rsz;
                mem_addr = a_reg - AW'(8);
            end
            nfa_pkg::OP_M2: begin
                p_next = a_reg - rsz;
                n_next = a_reg + s_reg;
                mem_addr = a_reg - rsz - AW'(4);
            end
            nfa_pkg::OP_M3: begin
                psz_next = rsz;
                mem_addr = p_reg + rsz - AW'(8);
            end
            nfa_pkg::OP_M4: begin
                pa_next = ral;
                mem_addr = n_reg - AW'(4);
            end
            nfa_pkg::OP_M5: nsz_next = rsz;
            nfa_pkg::OP_MA1: begin
                s_next = s_reg + nsz_reg;
                mem_we = 1'b1; mem_wdata = 32'(s_reg + nsz_reg);
            end
            nfa_pkg::OP_MA2: begin
                mem_addr = a_reg + s_reg - AW'(8); mem_we = 1'b1;
            end
            nfa_pkg::OP_MB1: begin
                s_next = s_reg + psz_reg;
                mem_addr = a_reg + s_reg - AW'(8); mem_we = 1'b1;
                mem_wdata = 32'(s_reg + psz_reg);
            end
            nfa_pkg::OP_MB2: begin
                mem_addr = p_reg - AW'(4); mem_we = 1'b1;
                a_next = p_reg;
            end
            nfa_pkg::OP_MC_RD: mem_addr = n_reg + nsz_reg - AW'(8);
            nfa_pkg::OP_MC_1: begin
                s_next = s_reg + psz_reg + rsz;
                mem_addr = p_reg - AW'(4); mem_we = 1'b1;
                mem_wdata = 32'(s_reg + psz_reg + rsz);
            end
            nfa_pkg::OP_MC_RD2: mem_addr = n_reg - AW'(4);
            nfa_pkg::OP_MC_2: begin
                mem_addr = n_reg + rsz - AW'(8); mem_we = 1'b1;
                a_next = p_reg;
            end
            nfa_pkg::OP_M_END: rover_next = a_reg;
            nfa_pkg::OP_F_START: begin
                a_next = rover_reg;
                start_next = rover_reg;
                cnt_next = '0;
            end
            nfa_pkg::OP_F0: begin
            end
            nfa_pkg::OP_F1: begin
                mem_addr = a_adv - AW'(4);
                if (!sts.found) begin
                    a_next = a_adv;
                end
            end
            nfa_pkg::OP_F2: begin
                a_next = a_wrap;
                mem_addr = a_wrap - AW'(4);
                cnt_next = cnt_reg + CW'(1);
            end
            nfa_pkg::OP_GROW_REQ: begin
                g_next = (need_reg > {1'b0, chunk_reg}) ? need_reg : {1'b0, chunk_reg};
            end
            nfa_pkg::OP_C0: begin
            end
            nfa_pkg::OP_C1: begin
                have_next = rsz;
                res_next = a_reg[15:0];
                mem_we = 1'b1;
                mem_wdata = sts.split ? {14'd0, need_reg} | 32'd1 : rsz[31:0] | 32'd1;
            end
            nfa_pkg::OP_C2S: begin
                mem_addr = a_reg + need_a - AW'(8); mem_we = 1'b1;
                mem_wdata = {14'd0, need_reg} | 32'd1;
                a_next = a_reg + need_a;
            end
            nfa_pkg::OP_C3: begin
                mem_we = 1'b1; mem_wdata = 32'(have_reg - need_a);
            end
            nfa_pkg::OP_C4: begin
                mem_addr = a_reg + (have_reg - need_a) - AW'(8); mem_we = 1'b1;
                mem_wdata = 32'(have_reg - need_a);
                rover_next = a_reg;
            end
            nfa_pkg::OP_C2N: begin
                mem_addr = a_reg + have_reg - AW'(8); mem_we = 1'b1;
                mem_wdata = have_reg[31:0] | 32'd1;
            end
            nfa_pkg::OP_R0: begin
            end
            nfa_pkg::OP_R1: begin
                s_next = rsz;
                mem_we = 1'b1; mem_wdata = rsz[31:0];
            end
            nfa_pkg::OP_R2: begin
                mem_addr = a_reg + s_reg - AW'(8); mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // single-port store; tag accesses beyond it read as allocated, zero size
    always_ff @(posedge aclk) begin
        if (mem_we && mem_inr) begin
            mem[mem_addr[IW+1:2]] <= mem_wdata;
        end
        q_reg   <= mem[mem_addr[IW+1:2]];
        oob_reg <= !mem_inr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brk_reg   <= '0;
            rover_reg <= '0;
            init_reg  <= 1'b0;
            chunk_reg <= nfa_pkg::CHUNK_RESET;
            cnt_reg   <= '0;
            kind_reg  <= nfa_pkg::KIND_INIT;
            stat_reg  <= nfa_pkg::STAT_OK;
            pa_reg    <= 1'b0;
        end else begin
            brk_reg   <= brk_next;
            rover_reg <= rover_next;
            init_reg  <= init_next;
            chunk_reg <= cfg_we ? cfg_data : chunk_reg;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
            stat_reg  <= stat_next;
            pa_reg    <= pa_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next; s_reg <= s_next; p_reg <= p_next; n_reg <= n_next;
        psz_reg <= psz_next; nsz_reg <= nsz_next; start_reg <= start_next;
        have_reg <= have_next; g_reg <= g_next; need_reg <= need_next;
        res_reg <= res_next; oaddr_reg <= oaddr_next; ostat_reg <= ostat_next;
        rzero_reg <= rzero_next; fok_reg <= fok_next;
    end

    assign out_result_addr = oaddr_reg;
    assign out_status      = ostat_reg;

endmodule

// ===== src/nfa_ctrl.sv =====
`timescale 1ns / 1ps

module nfa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  nfa_pkg::sts_t sts,
    output nfa_pkg::cmd_t cmd
);

    localparam logic [5:0] S_IDLE     = nfa_pkg::OP_NOP;
    localparam logic [5:0] S_DISPATCH = 6'd41;
    localparam logic [5:0] S_RET      = 6'd42;
    localparam logic [5:0] S_EMIT     = 6'd43;

    localparam logic [1:0] RET_INIT  = 2'd0;
    localparam logic [1:0] RET_ALLOC = 2'd1;
    localparam logic [1:0] RET_FREE  = 2'd2;

    logic [5:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic       fail_reg, fail_next;
    logic       mv_reg, mv_next;
    logic       failed;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    // a free that reaches the merge always answers ok, whatever the merge left behind
    assign failed  = fail_reg || (sts.a_zero && (ret_reg != RET_FREE));

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fail_next  = fail_reg;
        mv_next    = mv_reg && !m_ready;
        cmd.op     = state_reg;
        cmd.code   = nfa_pkg::STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                fail_next = 1'b0;
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.op = nfa_pkg::OP_SETSTAT;
                state_next = S_EMIT;
                unique case (sts.kind)
                    nfa_pkg::KIND_INIT: begin
                        ret_next = RET_INIT;
                        state_next = nfa_pkg::OP_INIT0;
                    end
                    nfa_pkg::KIND_ALLOC: begin
                        ret_next = RET_ALLOC;
                        priority if (!sts.init) begin
                            cmd.code = nfa_pkg::STAT_NO_INIT;
                        end else if (sts.req_zero) begin
                            cmd.code = nfa_pkg::STAT_ZERO;
                        end else begin
                            state_next = nfa_pkg::OP_F_START;
                        end
                    end
                    nfa_pkg::KIND_FREE: begin
                        ret_next = RET_FREE;
                        priority if (!sts.init) begin
                            cmd.code = nfa_pkg::STAT_NO_INIT;
                        end else if (sts.free_ok) begin
                            state_next = nfa_pkg::OP_R0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RET: begin
                cmd.op = nfa_pkg::OP_SETSTAT;
                cmd.code = failed ? nfa_pkg::STAT_NO_MEM : nfa_pkg::STAT_OK;
                state_next = S_EMIT;
                if (!failed && ret_reg == RET_INIT) begin
                    state_next = nfa_pkg::OP_SET_INIT;
                end else if (!failed && ret_reg == RET_ALLOC) begin
                    state_next = nfa_pkg::OP_C0;
                end
            end
            S_EMIT: begin
                cmd.op = nfa_pkg::OP_NOP;
                if (!mv_reg || m_ready) begin
                    cmd.op = nfa_pkg::OP_EMIT;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            nfa_pkg::OP_SET_INIT: state_next = S_EMIT;
            nfa_pkg::OP_INIT0: state_next = nfa_pkg::OP_INIT1;
            nfa_pkg::OP_INIT1: state_next = nfa_pkg::OP_INIT2;
            nfa_pkg::OP_INIT2: state_next = nfa_pkg::OP_INIT3;
            nfa_pkg::OP_INIT3: state_next = nfa_pkg::OP_G0;
            nfa_pkg::OP_G0: begin
                if (sts.fits) begin
                    state_next = nfa_pkg::OP_G1;
                end else begin
                    fail_next = 1'b1;
                    state_next = S_RET;
                end
            end
            nfa_pkg::OP_G1: state_next = nfa_pkg::OP_G2;
            nfa_pkg::OP_G2: state_next = nfa_pkg::OP_G3;
            nfa_pkg::OP_G3: state_next = nfa_pkg::OP_M0;
            nfa_pkg::OP_M0: state_next = nfa_pkg::OP_M1;
            nfa_pkg::OP_M1: state_next = nfa_pkg::OP_M2;
            nfa_pkg::OP_M2: state_next = nfa_pkg::OP_M3;
            nfa_pkg::OP_M3: state_next = nfa_pkg::OP_M4;
            nfa_pkg::OP_M4: state_next = nfa_pkg::OP_M5;
            nfa_pkg::OP_M5: begin
                unique case ({sts.pa, sts.na})
                    2'b10: state_next = nfa_pkg::OP_MA1;
                    2'b01: state_next = nfa_pkg::OP_MB1;
                    2'b00: state_next = nfa_pkg::OP_MC_RD;
                    default: state_next = nfa_pkg::OP_M_END;
                endcase
            end
            nfa_pkg::OP_MA1: state_next = nfa_pkg::OP_MA2;
            nfa_pkg::OP_MA2: state_next = nfa_pkg::OP_M_END;
            nfa_pkg::OP_MB1: state_next = nfa_pkg::OP_MB2;
            nfa_pkg::OP_MB2: state_next = nfa_pkg::OP_M_END;
            nfa_pkg::OP_MC_RD: state_next = nfa_pkg::OP_MC_1;
            nfa_pkg::OP_MC_1: state_next = nfa_pkg::OP_MC_RD2;
            nfa_pkg::OP_MC_RD2: state_next = nfa_pkg::OP_MC_2;
            nfa_pkg::OP_MC_2: state_next = nfa_pkg::OP_M_END;
            nfa_pkg::OP_M_END: state_next = S_RET;
            nfa_pkg::OP_F_START: state_next = nfa_pkg::OP_F0;
            nfa_pkg::OP_F0: state_next = nfa_pkg::OP_F1;
            nfa_pkg::OP_F1: begin
                state_next = sts.found ? nfa_pkg::OP_C0 : nfa_pkg::OP_F2;
            end
            nfa_pkg::OP_F2: begin
                state_next = sts.stop ? nfa_pkg::OP_GROW_REQ : nfa_pkg::OP_F1;
            end
            nfa_pkg::OP_GROW_REQ: state_next = nfa_pkg::OP_G0;
            nfa_pkg::OP_C0: state_next = nfa_pkg::OP_C1;
            nfa_pkg::OP_C1: begin
                state_next = sts.split ? nfa_pkg::OP_C2S : nfa_pkg::OP_C2N;
            end
            nfa_pkg::OP_C2S: state_next = nfa_pkg::OP_C3;
            nfa_pkg::OP_C3: state_next = nfa_pkg::OP_C4;
            nfa_pkg::OP_C4: state_next = S_EMIT;
            nfa_pkg::OP_C2N: state_next = S_EMIT;
            nfa_pkg::OP_R0: state_next = nfa_pkg::OP_R1;
            nfa_pkg::OP_R1: state_next = nfa_pkg::OP_R2;
            nfa_pkg::OP_R2: state_next = nfa_pkg::OP_M0;
            default: begin
                cmd.op = nfa_pkg::OP_NOP;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_INIT;
            fail_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fail_reg  <= fail_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

// ===== src/next_fit_heap_allocator.sv =====
`timescale 1ns / 1ps

// Next-fit heap allocator over an on-chip store of boundary-tagged blocks.
// Input channel s_*: one item per operation (kind 0 init, 1 allocate,
// 2 free) with request_size and block_addr. Result channel m_*: one item
// per input item carrying result_addr and status.
// Configuration channel cfg_*: writes chunk_bytes, the minimum heap
// extension; write it only while no operation is in flight.
// One item is worked on at a time. The single-port store allows one tag
// access per cycle, so the time an item takes grows with its tag accesses:
// rejected requests, unused kinds and ignored frees go straight to the
// result; init writes the first tags and tries to extend the heap by a
// first chunk; free merges the block with its free neighbours; allocate
// walks the block headers in the fit search and extends the heap when no
// block fits. The next item is taken only once the result is emitted.
// A finished result sits in the output register; a result only waits in
// its last step while the receiver stalls.
// Reset (aresetn, synchronous) leaves the heap uninitialised, break and
// rover at zero and chunk_bytes at 4096; no clearing pass is needed.
module next_fit_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [16:0] s_request_size,
    input  logic [15:0] s_block_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_addr,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    nfa_pkg::cmd_t cmd;
    nfa_pkg::sts_t sts;
    logic          in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;

    nfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nfa_dpath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_accept       (in_accept),
        .in_kind         (s_kind),
        .in_request_size (s_request_size),
        .in_block_addr   (s_block_addr),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .out_result_addr (m_result_addr),
        .out_status      (m_status)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("item accepted while another is in flight");

    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == nfa_pkg::STAT_OK || m_result_addr == 16'd0))
        else $error("failed request returned an address");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or busy after reset");

endmodule
